// ----- hw/rtl/xsmp_pkg.sv -----
// Shared types, constants and generator functions for the xoshiro coefficient sampler.
// No dependencies; every other file of the block refers to this package by scoped names.
package xsmp_pkg;

  localparam int unsigned COEF_W  = 12;
  localparam int unsigned MOD_W   = 13;
  localparam int unsigned ETA_W   = 5;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned DRAW_W  = 32;
  localparam int unsigned VAL_W   = 14;

  localparam logic [MOD_W-1:0] MOD_RESET = 13'd3329;
  localparam logic [MOD_W-1:0] MOD_MIN   = 13'd2;
  localparam logic [MOD_W-1:0] MOD_MAX   = 13'd4096;
  localparam logic [ETA_W-1:0] ETA_MAX   = 5'd16;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Command codes match the input kind field; the remaining kind codes carry no work.
  typedef enum logic [KIND_W-1:0] {
    OP_LOAD    = 3'd0,
    OP_FINISH  = 3'd1,
    OP_DEFAULT = 3'd2,
    OP_UNIFORM = 3'd3,
    OP_CBD     = 3'd4
  } op_t;

  typedef logic [3:0][WORD_W-1:0] gen_t;

  localparam gen_t GEN_DEFAULT = {
    64'h1234567890abcdef,
    64'h9c2c1d3e4f5a6b7c,
    64'hda3e39cb94b95bdb,
    64'h853c49e6748fea9b
  };

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  word_index;
    logic [WORD_W-1:0] seed_word;
    logic [ETA_W-1:0]  eta;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // One xoshiro256 state transition.
  function automatic gen_t gen_next(input gen_t g);
    gen_t              n;
    logic [WORD_W-1:0] sh;
    sh   = {g[1][WORD_W-18:0], 17'd0};
    n[2] = g[2] ^ g[0];
    n[3] = g[3] ^ g[1];
    n[1] = g[1] ^ n[2];
    n[0] = g[0] ^ n[3];
    n[2] = n[2] ^ sh;
    n[3] = {n[3][WORD_W-46:0], n[3][WORD_W-1:WORD_W-45]};
    return n;
  endfunction

  function automatic logic [WORD_W-1:0] times5(input logic [WORD_W-1:0] w);
    return w + {w[WORD_W-3:0], 2'b00};
  endfunction

  // Upper half of rotl(p, 7) * 9, where p already holds word1 * 5.
  function automatic logic [DRAW_W-1:0] gen_draw(input logic [WORD_W-1:0] p);
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    y = {p[WORD_W-8:0], p[WORD_W-1:WORD_W-7]};
    z = y + {y[WORD_W-4:0], 3'b000};
    return z[WORD_W-1:WORD_W-DRAW_W];
  endfunction

  function automatic logic [MOD_W-1:0] mod_clamp(input logic [MOD_W-1:0] m);
    logic [MOD_W-1:0] r;
    r = m;
    if (m < MOD_MIN) r = MOD_MIN;
    if (m > MOD_MAX) r = MOD_MAX;
    return r;
  endfunction

endpackage

// ----- hw/rtl/xsmp_if.sv -----
// Channel interfaces of the xoshiro coefficient sampler: request channel and result channel.
// Depends on xsmp_pkg for field widths.
interface xsmp_in_if;
  logic                        valid;
  logic                        ready;
  logic [xsmp_pkg::KIND_W-1:0] kind;
  logic [xsmp_pkg::IDX_W-1:0]  word_index;
  logic [xsmp_pkg::WORD_W-1:0] seed_word;
  logic [xsmp_pkg::ETA_W-1:0]  eta;

  modport source (output valid, output kind, output word_index, output seed_word,
                  output eta, input ready);
  modport sink (input valid, input kind, input word_index, input seed_word,
                input eta, output ready);
endinterface

interface xsmp_out_if;
  logic                        valid;
  logic                        ready;
  logic [xsmp_pkg::COEF_W-1:0] coefficient;

  modport source (output valid, output coefficient, input ready);
  modport sink (input valid, input coefficient, output ready);
endinterface

// ----- hw/rtl/xsmp_front.sv -----
// Front end: accepts request beats, drops unused kinds and turns the rest into commands.
// Depends on xsmp_pkg and xsmp_in_if; feeds xsmp_queue.
module xsmp_front (
  xsmp_in_if.sink              in_if,
  input  xsmp_pkg::q_status_t  q_stat,
  output logic                 push,
  output xsmp_pkg::cmd_t       push_cmd
);

  logic keep;

  assign in_if.ready = !q_stat.full;

  always_comb begin
    unique case (in_if.kind)
      xsmp_pkg::OP_LOAD, xsmp_pkg::OP_FINISH, xsmp_pkg::OP_DEFAULT,
      xsmp_pkg::OP_UNIFORM, xsmp_pkg::OP_CBD: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_comb begin
    push_cmd.op         = xsmp_pkg::op_t'(in_if.kind);
    push_cmd.word_index = in_if.word_index;
    push_cmd.seed_word  = in_if.seed_word;
    push_cmd.eta        = (in_if.eta > xsmp_pkg::ETA_MAX) ? xsmp_pkg::ETA_MAX : in_if.eta;
  end

  assign push = in_if.valid && in_if.ready && keep;

endmodule

// ----- hw/rtl/xsmp_queue.sv -----
// Short command queue between the front end and the sampling engine.
// Depends on xsmp_pkg for the command type and depth.
module xsmp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  xsmp_pkg::cmd_t       push_cmd,
  input  logic                 pop,
  output xsmp_pkg::cmd_t       pop_cmd,
  output xsmp_pkg::q_status_t  q_stat
);

  localparam int unsigned PW = xsmp_pkg::Q_PTR_W;
  localparam int unsigned CW = xsmp_pkg::Q_CNT_W;

  xsmp_pkg::cmd_t  mem_r [xsmp_pkg::Q_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == CW'(xsmp_pkg::Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_cmd      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(xsmp_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(xsmp_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("command queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("command queue read while empty");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(xsmp_pkg::Q_DEPTH))
    else $error("command queue count beyond depth");

endmodule

// ----- hw/rtl/xsmp_back.sv -----
// Sampling engine: generator state, seed commands, rejection and binomial sampling,
// modulus register and result register. Depends on xsmp_pkg and xsmp_out_if.
module xsmp_back #(
  parameter int unsigned LOG_MODULUS = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  xsmp_pkg::q_status_t            q_stat,
  input  xsmp_pkg::cmd_t                 q_cmd,
  output logic                           q_pop,
  input  logic                           cfg_we,
  input  logic [xsmp_pkg::MOD_W-1:0]     cfg_data,
  xsmp_out_if.source                     out_if
);

  localparam int unsigned CMP_W =
    (LOG_MODULUS > xsmp_pkg::MOD_W) ? LOG_MODULUS : xsmp_pkg::MOD_W;
  localparam int unsigned VW = xsmp_pkg::VAL_W;
  localparam int unsigned CNT_W = xsmp_pkg::ETA_W;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_STEP   = 5'b00010,
    ST_DRAW   = 5'b00100,
    ST_CBD    = 5'b01000,
    ST_REDUCE = 5'b10000
  } state_t;

  state_t                            state_r, state_nxt;
  xsmp_pkg::gen_t                    gen_r, gen_nxt;
  logic [xsmp_pkg::WORD_W-1:0]       p_r, p_nxt;
  logic [xsmp_pkg::DRAW_W-1:0]       d_r, d_nxt;
  logic signed [VW-1:0]              v_r, v_nxt;
  xsmp_pkg::op_t                     op_r, op_nxt;
  logic [xsmp_pkg::ETA_W-1:0]        eta_r, eta_nxt;
  logic [xsmp_pkg::MOD_W-1:0]        mod_r;
  logic                              ovalid_r, ovalid_nxt;
  logic [xsmp_pkg::COEF_W-1:0]       coef_r, coef_nxt;

  logic [xsmp_pkg::MOD_W-1:0]        m_work;
  logic signed [VW-1:0]              m_s;
  logic [xsmp_pkg::DRAW_W-1:0]       draw;
  logic [CMP_W-1:0]                  r_ext;
  logic                              uni_ok;
  logic                              slot_free;
  logic [15:0]                       lo_mask;
  logic [xsmp_pkg::DRAW_W-1:0]       hi_bits;
  logic [CNT_W-1:0]                  cnt_a, cnt_b;
  logic signed [VW-1:0]              v_cbd;

  assign m_work    = xsmp_pkg::mod_clamp(mod_r);
  assign m_s       = $signed({1'b0, m_work});
  assign draw      = xsmp_pkg::gen_draw(p_r);
  assign r_ext     = CMP_W'(draw[LOG_MODULUS-1:0]);
  assign uni_ok    = r_ext < CMP_W'(m_work);
  assign slot_free = !ovalid_r || out_if.ready;

  // Centered binomial: ones in the low eta bits minus ones in the next eta bits.
  assign lo_mask = 16'((17'd1 << eta_r) - 17'd1);
  assign hi_bits = d_r >> eta_r;
  assign cnt_a   = CNT_W'($countones(d_r[15:0] & lo_mask));
  assign cnt_b   = CNT_W'($countones(hi_bits[15:0] & lo_mask));
  assign v_cbd   = $signed(VW'(cnt_a)) - $signed(VW'(cnt_b));

  assign q_pop = (state_r == ST_IDLE) && !q_stat.empty;

  assign out_if.valid       = ovalid_r;
  assign out_if.coefficient = coef_r;

  always_comb begin
    state_nxt  = state_r;
    gen_nxt    = gen_r;
    p_nxt      = p_r;
    d_nxt      = d_r;
    v_nxt      = v_r;
    op_nxt     = op_r;
    eta_nxt    = eta_r;
    coef_nxt   = coef_r;
    ovalid_nxt = ovalid_r && !out_if.ready;

    unique case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          unique case (q_cmd.op)
            xsmp_pkg::OP_LOAD: begin
              gen_nxt[q_cmd.word_index] = q_cmd.seed_word;
            end
            xsmp_pkg::OP_FINISH: begin
              if (gen_r == '0) gen_nxt = xsmp_pkg::GEN_DEFAULT;
            end
            xsmp_pkg::OP_DEFAULT: begin
              gen_nxt = xsmp_pkg::GEN_DEFAULT;
            end
            xsmp_pkg::OP_UNIFORM, xsmp_pkg::OP_CBD: begin
              op_nxt    = q_cmd.op;
              eta_nxt   = q_cmd.eta;
              state_nxt = ST_STEP;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_STEP: begin
        p_nxt     = xsmp_pkg::times5(gen_r[1]);
        gen_nxt   = xsmp_pkg::gen_next(gen_r);
        state_nxt = ST_DRAW;
      end
      ST_DRAW: begin
        d_nxt = draw;
        if (op_r == xsmp_pkg::OP_CBD) begin
          state_nxt = ST_CBD;
        end else if (!uni_ok) begin
          // Rejected draw: the next generator step overlaps this cycle.
          p_nxt   = xsmp_pkg::times5(gen_r[1]);
          gen_nxt = xsmp_pkg::gen_next(gen_r);
        end else if (slot_free) begin
          coef_nxt   = r_ext[xsmp_pkg::COEF_W-1:0];
          ovalid_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_CBD: begin
        v_nxt     = v_cbd;
        state_nxt = ST_REDUCE;
      end
      ST_REDUCE: begin
        if (v_r < 0) begin
          v_nxt = v_r + m_s;
        end else if (v_r >= m_s) begin
          v_nxt = v_r - m_s;
        end else if (slot_free) begin
          coef_nxt   = v_r[xsmp_pkg::COEF_W-1:0];
          ovalid_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      gen_r    <= xsmp_pkg::GEN_DEFAULT;
      mod_r    <= xsmp_pkg::MOD_RESET;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      gen_r    <= gen_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we) mod_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= p_nxt;
    d_r    <= d_nxt;
    v_r    <= v_nxt;
    op_r   <= op_nxt;
    eta_r  <= eta_nxt;
    coef_r <= coef_nxt;
  end

  a_coef_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (xsmp_pkg::MOD_W'(coef_r) < m_work))
    else $error("pending coefficient not below the modulus");

  a_reduce_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REDUCE) |-> ((v_r > -14'sd17) && (v_r < m_s + 14'sd17)))
    else $error("binomial value outside its reduction window");

  a_gen_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_CBD) || (state_r == ST_REDUCE)) |=> $stable(gen_r))
    else $error("generator state moved outside a draw");

endmodule

// ----- hw/rtl/xoshiro_polynomial_coefficient_sampler.sv -----
// Top level of the xoshiro256** coefficient sampler: front end, command queue, engine.
// Depends on xsmp_pkg, xsmp_if, xsmp_front, xsmp_queue and xsmp_back.
//
//   channel   direction  beat contents
//   in_if     sink       kind, word_index, seed_word, eta
//   out_if    source     coefficient
//   cfg_*     write      modulus (13 bits)
//
// The engine handles one command at a time. Seed beats are applied as they are popped.
// A uniform sample runs through the step and draw states to the result register, a
// rejected draw repeating the step in the draw state; a binomial sample runs through
// step, draw, binomial and reduce, the reduce loop adding or subtracting the modulus
// once per cycle. Reset is synchronous and loads the default seed and a modulus of 3329.
// The two-entry queue keeps taking beats while not full, also while a result waits in the output register.
module xoshiro_polynomial_coefficient_sampler #(
  parameter int unsigned LOG_MODULUS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  xsmp_in_if.sink                     in_if,
  xsmp_out_if.source                  out_if,
  input  logic                        cfg_we,
  input  logic [xsmp_pkg::MOD_W-1:0]  cfg_data
);

  xsmp_pkg::q_status_t q_stat;
  xsmp_pkg::cmd_t      push_cmd;
  xsmp_pkg::cmd_t      pop_cmd;
  logic                push;
  logic                pop;

  xsmp_front u_front (
    .in_if    (in_if),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  xsmp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat)
  );

  xsmp_back #(
    .LOG_MODULUS (LOG_MODULUS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .q_cmd    (pop_cmd),
    .q_pop    (pop),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .out_if   (out_if)
  );

endmodule
